// ===== src/tlfs_pkg.sv =====
// Package for the three-level feedback scheduler.
// Types, constants and state codes shared by controller, datapath and top level.
// No dependencies.
package tlfs_pkg;

	localparam int MAX_PROCS_DEF = 32;
	localparam int ID_W = 5;

	localparam logic [1:0] CFG_Q1 = 2'd0;
	localparam logic [1:0] CFG_Q2 = 2'd1;
	localparam logic [1:0] CFG_Q3 = 2'd2;
	localparam logic [1:0] CFG_BP = 2'd3;

	typedef struct packed {
		logic            kind;
		logic [ID_W-1:0] proc_id;
		logic [15:0]     burst_length;
	} in_item_t;

	typedef struct packed {
		logic            rejected;
		logic            idle;
		logic [ID_W-1:0] ran_id;
		logic [1:0]      ran_level;
		logic            finished;
		logic [15:0]     turnaround;
		logic [15:0]     waiting;
		logic [15:0]     response;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ARRIVE,
		ST_REQUEUE,
		ST_MERGE_RD,
		ST_MERGE_WR,
		ST_PICK,
		ST_POP_RD,
		ST_LOAD,
		ST_RUN,
		ST_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic arrive;      // write process tables and push level 1
		logic requeue;     // push pending process
		logic merge_rd;    // read head of merge source
		logic merge_wr;    // append merge word to level 1
		logic pick;        // latch highest non-empty level
		logic pop_rd;      // read head of picked level
		logic load;        // take popped id as runner, read its tables
		logic run;         // run one unit and form the result
		logic clr_pend;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic arr_ok;
		logic pend_req;
		logic pend_shift;
		logic merge_more;  // level 2 or 3 still holds entries
		logic need_pick;   // no runner and some level non-empty
	} stat_t;

endpackage

// ===== src/tlfs_ctrl.sv =====
// Controller state machine of the three-level feedback scheduler.
// Sequences arrival, requeue, merge, dispatch and run steps; uses tlfs_pkg.
module tlfs_ctrl import tlfs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_kind,
	input  logic      out_busy,
	input  stat_t     stat,
	output logic      in_ready,
	output cmd_t      cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && !out_busy) begin
					if (!in_kind) state_d = ST_ARRIVE;
					else if (stat.pend_req) state_d = ST_REQUEUE;
					else if (stat.pend_shift) state_d = ST_MERGE_RD;
					else state_d = ST_PICK;
				end
			end
			ST_ARRIVE:   state_d = ST_IDLE;
			ST_REQUEUE:  state_d = stat.pend_shift ? ST_MERGE_RD : ST_PICK;
			ST_MERGE_RD: state_d = stat.merge_more ? ST_MERGE_WR : ST_PICK;
			ST_MERGE_WR: state_d = ST_MERGE_RD;
			ST_PICK:     state_d = stat.need_pick ? ST_POP_RD : ST_RUN;
			ST_POP_RD:   state_d = ST_LOAD;
			ST_LOAD:     state_d = ST_RUN;
			ST_RUN:      state_d = ST_DONE;
			ST_DONE:     state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE:     in_ready = !out_busy;
			ST_ARRIVE:   cmd.arrive = 1'b1;
			ST_REQUEUE:  cmd.requeue = 1'b1;
			ST_MERGE_RD: cmd.merge_rd = 1'b1;
			ST_MERGE_WR: cmd.merge_wr = 1'b1;
			ST_PICK: begin
				cmd.pick = 1'b1;
				cmd.clr_pend = 1'b1;
			end
			ST_POP_RD:   cmd.pop_rd = 1'b1;
			ST_LOAD:     cmd.load = 1'b1;
			ST_RUN:      cmd.run = 1'b1;
			default:     ;
		endcase
	end

endmodule

// ===== src/tlfs_dp.sv =====
// Datapath of the three-level feedback scheduler: level queues in one memory,
// per-process tables, runner, timers and result register. Uses tlfs_pkg.
module tlfs_dp import tlfs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic [1:0] cfg_idx,
	input  logic [15:0] cfg_data,
	input  logic      accept,
	input  in_item_t  in_item,
	input  cmd_t      cmd,
	output stat_t     stat,
	output logic      res_load,
	output out_item_t res
);

	localparam int MAX_PROCS = MAX_PROCS_DEF;
	localparam int AW = $clog2(MAX_PROCS);
	localparam int CW = $clog2(MAX_PROCS + 1);
	localparam logic [CW-1:0] FULL = CW'(MAX_PROCS);

	// configuration
	logic [7:0] q1_q, q2_q, q3_q;
	logic [15:0] bp_q, bcnt_q;

	// queue memory: level in upper bits
	logic [ID_W-1:0] qmem [3*MAX_PROCS];
	logic [AW-1:0] head_q [3];
	logic [CW-1:0] cnt_q [3];

	// per-process tables
	logic [15:0] rem_mem [MAX_PROCS];
	logic [15:0] tot_mem [MAX_PROCS];
	logic [31:0] arr_mem [MAX_PROCS];
	logic [15:0] resp_mem [MAX_PROCS];
	logic [MAX_PROCS-1:0] busy_q, started_q;

	logic [31:0] time_q;
	logic run_v_q;
	logic [AW-1:0] run_id_q;
	logic [1:0] run_lv_q;
	logic [7:0] slice_q;
	logic pend_req_q, pend_shift_q;
	logic [AW-1:0] pend_id_q;
	logic [1:0] pend_lv_q;
	logic [1:0] pick_q;
	logic [ID_W-1:0] rd_q;
	logic [15:0] rem_q, tot_q, resp_q;
	logic [31:0] arr_q;
	in_item_t item_q;
	out_item_t res_d;

	logic [AW-1:0] aid;
	assign aid = item_q.proc_id[AW-1:0];
	logic id_ok;
	assign id_ok = (32'(item_q.proc_id) < MAX_PROCS);
	assign stat.arr_ok = id_ok && (item_q.burst_length != 16'd0) && !busy_q[aid];
	assign stat.pend_req = pend_req_q;
	assign stat.pend_shift = pend_shift_q;
	assign stat.merge_more = (cnt_q[1] != '0) || (cnt_q[2] != '0);
	assign stat.need_pick = !run_v_q &&
		((cnt_q[0] != '0) || (cnt_q[1] != '0) || (cnt_q[2] != '0));

	// merge source: level 2 first
	logic [1:0] msrc;
	assign msrc = (cnt_q[1] != '0) ? 2'd1 : 2'd2;

	function automatic logic [AW+1:0] qaddr(input logic [1:0] lv, input logic [AW-1:0] off);
		qaddr = (AW+2)'(lv) * (AW+2)'(MAX_PROCS) + (AW+2)'(off);
	endfunction

	function automatic logic [AW-1:0] wrap(input logic [AW-1:0] h, input logic [CW-1:0] c);
		logic [CW:0] s;
		s = (CW+1)'(h) + (CW+1)'(c);
		if (s >= (CW+1)'(MAX_PROCS)) s = s - (CW+1)'(MAX_PROCS);
		wrap = s[AW-1:0];
	endfunction

	function automatic logic [15:0] sat16(input logic [31:0] v);
		sat16 = (v > 32'd65535) ? 16'hFFFF : v[15:0];
	endfunction

	// push logic
	logic push_en;
	logic [1:0] push_lv;
	logic [ID_W-1:0] push_id;
	always_comb begin
		push_en = 1'b0;
		push_lv = 2'd0;
		push_id = '0;
		if (cmd.arrive && stat.arr_ok) begin
			push_en = 1'b1;
			push_id = item_q.proc_id;
		end else if (cmd.requeue) begin
			push_en = 1'b1;
			push_lv = pend_lv_q - 2'd1;
			push_id = ID_W'(pend_id_q);
		end else if (cmd.merge_wr) begin
			push_en = 1'b1;
			push_id = rd_q;
		end
	end

	logic boost;
	assign boost = (bcnt_q <= 16'd1);
	logic [15:0] rem_dec;
	assign rem_dec = rem_q - 16'd1;
	logic [7:0] qsel, qeff;
	always_comb begin
		case (run_lv_q)
			2'd1: qsel = q1_q;
			2'd2: qsel = q2_q;
			default: qsel = q3_q;
		endcase
		qeff = (qsel == 8'd0) ? 8'd1 : qsel;
	end
	logic [31:0] tnext, ta;
	assign tnext = time_q + 32'd1;
	assign ta = tnext - arr_q;

	// result of the current step
	always_comb begin
		res_d = '0;
		if (cmd.run) begin
			res_d.idle = !run_v_q;
			if (run_v_q) begin
				res_d.ran_id = ID_W'(run_id_q);
				res_d.ran_level = run_lv_q;
				if (rem_dec == 16'd0) begin
					res_d.finished = 1'b1;
					res_d.turnaround = sat16(ta);
					res_d.waiting = (ta > 32'(tot_q)) ? sat16(ta - 32'(tot_q)) : 16'd0;
					res_d.response = resp_q;
				end
			end
		end else begin
			res_d.rejected = !stat.arr_ok;
		end
	end

	assign res_load = cmd.arrive || cmd.run;

	always_ff @(posedge clk) begin
		if (accept) item_q <= in_item;
		if (push_en)
			qmem[qaddr(push_lv, wrap(head_q[push_lv], cnt_q[push_lv]))] <= push_id;
		if (cmd.merge_rd) rd_q <= qmem[qaddr(msrc, head_q[msrc])];
		if (cmd.pop_rd) rd_q <= qmem[qaddr(pick_q, head_q[pick_q])];
		if (cmd.arrive && stat.arr_ok) begin
			tot_mem[aid] <= item_q.burst_length;
			arr_mem[aid] <= time_q;
		end
		if (cmd.load) begin
			tot_q <= tot_mem[rd_q[AW-1:0]];
			arr_q <= arr_mem[rd_q[AW-1:0]];
			// first dispatch: response is formed here, not read back
			resp_q <= started_q[rd_q[AW-1:0]] ? resp_mem[rd_q[AW-1:0]] :
				sat16(time_q - arr_mem[rd_q[AW-1:0]]);
			rem_q <= rem_mem[rd_q[AW-1:0]];
		end
		if (cmd.run && run_v_q) rem_q <= rem_dec;
		if (cmd.arrive && stat.arr_ok) rem_mem[aid] <= item_q.burst_length;
		else if (cmd.run && run_v_q) rem_mem[run_id_q] <= rem_dec;
		if (cmd.load && !started_q[rd_q[AW-1:0]])
			resp_mem[rd_q[AW-1:0]] <= sat16(time_q - arr_mem[rd_q[AW-1:0]]);
		if (cmd.run || cmd.arrive) res <= res_d;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q1_q <= 8'd4; q2_q <= 8'd8; q3_q <= 8'd16;
			bp_q <= 16'd64; bcnt_q <= 16'd64;
			for (int i = 0; i < 3; i++) begin
				head_q[i] <= '0;
				cnt_q[i] <= '0;
			end
			busy_q <= '0; started_q <= '0;
			time_q <= '0; run_v_q <= 1'b0; run_id_q <= '0; run_lv_q <= '0;
			slice_q <= '0; pend_req_q <= 1'b0; pend_shift_q <= 1'b0;
			pend_id_q <= '0; pend_lv_q <= '0; pick_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_Q1: q1_q <= cfg_data[7:0];
					CFG_Q2: q2_q <= cfg_data[7:0];
					CFG_Q3: q3_q <= cfg_data[7:0];
					CFG_BP: begin
						bp_q <= cfg_data;
						bcnt_q <= cfg_data;
					end
					default: ;
				endcase
			end
			if (push_en && cnt_q[push_lv] != FULL)
				cnt_q[push_lv] <= cnt_q[push_lv] + CW'(1);
			if (cmd.arrive && stat.arr_ok) begin
				busy_q[aid] <= 1'b1;
				started_q[aid] <= 1'b0;
			end
			if (cmd.merge_rd && stat.merge_more) begin
				head_q[msrc] <= wrap(head_q[msrc], CW'(1));
				cnt_q[msrc] <= cnt_q[msrc] - CW'(1);
			end
			if (cmd.clr_pend) begin
				pend_req_q <= 1'b0;
				pend_shift_q <= 1'b0;
			end
			if (cmd.pick) begin
				pick_q <= (cnt_q[0] != '0) ? 2'd0 : (cnt_q[1] != '0) ? 2'd1 : 2'd2;
			end
			if (cmd.pop_rd) begin
				head_q[pick_q] <= wrap(head_q[pick_q], CW'(1));
				cnt_q[pick_q] <= cnt_q[pick_q] - CW'(1);
			end
			if (cmd.load) begin
				run_v_q <= 1'b1;
				run_id_q <= rd_q[AW-1:0];
				run_lv_q <= pick_q + 2'd1;
				slice_q <= '0;
				started_q[rd_q[AW-1:0]] <= 1'b1;
			end
			if (cmd.run) begin
				time_q <= tnext;
				bcnt_q <= boost ? ((bp_q == 16'd0) ? 16'd1 : bp_q) : bcnt_q - 16'd1;
				if (run_v_q) begin
					slice_q <= slice_q + 8'd1;
					if (rem_dec == 16'd0) begin
						busy_q[run_id_q] <= 1'b0;
						run_v_q <= 1'b0;
						pend_shift_q <= boost;
					end else if (boost) begin
						pend_req_q <= 1'b1;
						pend_shift_q <= 1'b1;
						pend_id_q <= run_id_q;
						pend_lv_q <= (run_lv_q > 2'd1) ? run_lv_q - 2'd1 : 2'd1;
						run_v_q <= 1'b0;
					end else if (9'(slice_q) + 9'd1 >= 9'(qeff)) begin
						pend_req_q <= 1'b1;
						pend_id_q <= run_id_q;
						pend_lv_q <= (run_lv_q < 2'd3) ? run_lv_q + 2'd1 : 2'd3;
						run_v_q <= 1'b0;
					end
				end
			end
		end
	end

endmodule

// ===== src/three_level_feedback_scheduler_unit.sv =====
// Three-level feedback scheduler, top level. Depends on tlfs_pkg, tlfs_ctrl, tlfs_dp.
// An arrival passes through ARRIVE; a tick passes through PICK, RUN and DONE, preceded by
// REQUEUE for a requeue and by MERGE_RD/MERGE_WR steps for a level merge, with POP_RD
// and LOAD between PICK and RUN for a dispatch. One request is in work at a time; the
// next is taken once the result has left.
// Reset (arst_n low): queues empty, no runner, time zero, registers at defaults.
module three_level_feedback_scheduler_unit import tlfs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_item_t   in_data,
	output logic       out_valid,
	input  logic       out_stall,
	output out_item_t  out_data,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [15:0] cfg_data
);

	cmd_t cmd;
	stat_t stat;
	logic in_ready, res_load, accept;
	out_item_t res;

	assign in_stall = !in_ready;
	assign accept = in_valid && in_ready;

	tlfs_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_kind(in_data.kind),
		.out_busy(out_valid), .stat, .in_ready, .cmd
	);

	tlfs_dp u_dp (
		.clk, .arst_n, .cfg_we, .cfg_idx(cfg_index), .cfg_data,
		.accept, .in_item(in_data), .cmd, .stat, .res_load, .res
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (res_load) out_valid <= 1'b1;
		else if (!out_stall) out_valid <= 1'b0;
	end
	assign out_data = res;

endmodule
